// File: hw/rtl/lnps_pkg.sv
package lnps_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic CMD_PRESS   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic        command;
    logic [6:0]  note_number;
    logic [23:0] pitch_freq;
    logic [7:0]  key_velocity;
  } lnps_in_t;

  typedef struct packed {
    logic        sounding;
    logic [6:0]  top_note;
    logic [23:0] top_freq;
    logic [7:0]  top_velocity;
    logic [5:0]  held_count;
    logic [1:0]  status;
  } lnps_out_t;

  typedef struct packed {
    logic [6:0]  note;
    logic [23:0] freq;
    logic [7:0]  vel;
  } lnps_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic push;
    logic set_full;
    logic set_nf;
    logic scan_start;
    logic scan_step;
    logic shift_start;
    logic shift_step;
    logic dec;
    logic top_rd;
    logic out_load;
  } lnps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_press;
    logic cnt_zero;
    logic cnt_full;
    logic match;
    logic scan_miss;
    logic shift_done;
  } lnps_sts_t;

endpackage

// File: hw/rtl/last_note_priority_stack.sv
// Held-note stack for a monophonic voice with last-note priority. Each input
// word is a press (push note, frequency, velocity on top) or a release (drop
// the oldest entry with that note and close the gap, order kept). Every word
// answers with exactly one result word: the top entry, whether a note sounds,
// the count held and a status (ok, press dropped because the stack is full,
// released note not found). Frequency is Q14.10 and velocity 0..255; both
// pass through unchanged. Items are handled one at a time. The entry memory
// has one read and one write port, so the search walks one entry per cycle
// from the bottom and the gap closes one entry per cycle after the hit. A
// new word is accepted the cycle after a result is loaded, even while that
// result still waits in the output register; the next result then holds
// until that register frees up. Entries need no clearing after reset: only
// entries below the count are ever read. With STACK_DEPTH above 63,
// held_count carries the low 6 bits of the count.
module last_note_priority_stack #(
  parameter int STACK_DEPTH = lnps_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lnps_pkg::lnps_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lnps_pkg::lnps_out_t out_data
);
  import lnps_pkg::*;

  lnps_cmd_t cmd;
  lnps_sts_t sts;

  // sequencer: dispatch, scan, shift, top read, result handoff
  lnps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry memory, count, scan pointers and the output register
  lnps_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // one word in flight: ready drops right after an accept
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // a dropped press means the stack is full, so something sounds
  a_full_sounds : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> out_data.sounding)
    else $error("full status with nothing sounding");

  // silent result carries a zeroed top entry
  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.sounding) |->
      (out_data.top_note == '0 && out_data.top_freq == '0 &&
       out_data.top_velocity == '0))
    else $error("empty stack reports a nonzero top entry");

  // the unused status code never leaves the block
  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FULL ||
                   out_data.status == ST_NOT_FOUND))
    else $error("undefined status code");

endmodule

// File: hw/rtl/lnps_datapath.sv
module lnps_datapath #(
  parameter int STACK_DEPTH = lnps_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lnps_pkg::lnps_in_t  in_data,
  input  lnps_pkg::lnps_cmd_t cmd,
  output lnps_pkg::lnps_sts_t sts,
  output lnps_pkg::lnps_out_t out_data
);
  import lnps_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  lnps_entry_t mem [STACK_DEPTH];

  lnps_in_t    item_r, item_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  lnps_entry_t rd_data_r;
  logic [1:0]  status_r, status_nxt;
  lnps_out_t   out_r, out_nxt;

  logic [CW-1:0] cnt_m1;
  logic          cnt_zero;
  logic          issue;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  lnps_entry_t   wr_data;
  logic          match;

  assign cnt_m1   = cnt_r - 1'b1;
  assign cnt_zero = (cnt_r == '0);
  assign issue    = (cmd.scan_step || cmd.shift_step) && (idx_r < cnt_r);
  assign rd_en    = issue || (cmd.top_rd && !cnt_zero);
  assign rd_addr  = cmd.top_rd ? cnt_m1[AW-1:0] : idx_r[AW-1:0];
  assign wr_en    = cmd.push || (cmd.shift_step && rd_vld_r);
  assign wr_addr  = cmd.push ? cnt_r[AW-1:0] : AW'(rd_addr_r - 1'b1);
  assign match    = rd_vld_r && (rd_data_r.note == item_r.note_number);

  always_comb begin
    wr_data = rd_data_r;
    if (cmd.push) begin
      wr_data.note = item_r.note_number;
      wr_data.freq = item_r.pitch_freq;
      wr_data.vel  = item_r.key_velocity;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    item_nxt    = item_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    rd_vld_nxt  = rd_vld_r;
    rd_addr_nxt = rd_addr_r;
    status_nxt  = status_r;
    out_nxt     = out_r;
    if (cmd.load_item) begin
      item_nxt   = in_data;
      status_nxt = ST_OK;
    end
    if (cmd.set_full) begin
      status_nxt = ST_FULL;
    end
    if (cmd.set_nf) begin
      status_nxt = ST_NOT_FOUND;
    end
    if (cmd.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.dec) begin
      cnt_nxt = cnt_m1;
    end
    if (cmd.scan_start) begin
      idx_nxt    = '0;
      rd_vld_nxt = 1'b0;
    end
    if (cmd.shift_start) begin
      idx_nxt    = CW'(rd_addr_r) + 1'b1;
      rd_vld_nxt = 1'b0;
    end
    if (cmd.scan_step || cmd.shift_step) begin
      rd_vld_nxt = issue;
      if (issue) begin
        rd_addr_nxt = idx_r[AW-1:0];
        idx_nxt     = idx_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_nxt.sounding     = !cnt_zero;
      out_nxt.top_note     = cnt_zero ? '0 : rd_data_r.note;
      out_nxt.top_freq     = cnt_zero ? '0 : rd_data_r.freq;
      out_nxt.top_velocity = cnt_zero ? '0 : rd_data_r.vel;
      out_nxt.held_count   = 6'(cnt_r);
      out_nxt.status       = status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    rd_addr_r <= rd_addr_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    sts.is_press   = (item_r.command == CMD_PRESS);
    sts.cnt_zero   = cnt_zero;
    sts.cnt_full   = (cnt_r == CW'(STACK_DEPTH));
    sts.match      = match;
    sts.scan_miss  = rd_vld_r && !match && (rd_addr_r == cnt_m1[AW-1:0]);
    sts.shift_done = !rd_vld_r && (idx_r >= cnt_r);
  end

  assign out_data = out_r;

endmodule

// File: hw/rtl/lnps_ctrl.sv
module lnps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lnps_pkg::lnps_sts_t sts,
  output lnps_pkg::lnps_cmd_t cmd
);
  import lnps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_TOP   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_press) begin
          if (sts.cnt_full) begin
            cmd.set_full = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
          state_nxt = S_TOP;
        end else if (sts.cnt_zero) begin
          cmd.set_nf = 1'b1;
          state_nxt  = S_TOP;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.shift_start = 1'b1;
          state_nxt       = S_SHIFT;
        end else if (sts.scan_miss) begin
          cmd.set_nf = 1'b1;
          state_nxt  = S_TOP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.dec   = 1'b1;
          state_nxt = S_TOP;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_TOP: begin
        cmd.top_rd = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

// File: sim/lnps_scoreboard.sv
`timescale 1ns / 100ps

module lnps_scoreboard #(
  parameter int STACK_DEPTH = lnps_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lnps_pkg::lnps_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lnps_pkg::lnps_out_t out_data,
  output int                  fail_count,
  output int                  words_waiting,
  output int                  words_checked,
  output int                  full_drops,
  output int                  absent_releases,
  output int                  peak_depth
);
  import lnps_pkg::*;

  lnps_entry_t held_stack [STACK_DEPTH];
  int          held_n;
  lnps_out_t   answer_q [$];

  // Apply one press or release to the shadow stack and build the answer word.
  function automatic lnps_out_t play_event(lnps_in_t w);
    lnps_out_t  r;
    logic [1:0] st;
    int         hit;
    st  = ST_OK;
    hit = -1;
    if (w.command == CMD_PRESS) begin
      if (held_n >= STACK_DEPTH) begin
        st = ST_FULL;
      end else begin
        held_stack[held_n] = '{note: w.note_number, freq: w.pitch_freq,
                               vel: w.key_velocity};
        held_n++;
      end
    end else begin
      // oldest match wins, then close the gap
      for (int i = 0; i < held_n && hit < 0; i++)
        if (held_stack[i].note == w.note_number) hit = i;
      if (hit < 0) begin
        st = ST_NOT_FOUND;
      end else begin
        for (int j = hit; j + 1 < held_n; j++) held_stack[j] = held_stack[j + 1];
        held_n--;
      end
    end
    r = '0;
    if (held_n > 0) begin
      r.sounding     = 1'b1;
      r.top_note     = held_stack[held_n - 1].note;
      r.top_freq     = held_stack[held_n - 1].freq;
      r.top_velocity = held_stack[held_n - 1].vel;
    end
    r.held_count = held_n[5:0];
    r.status     = st;
    return r;
  endfunction

  function automatic int off_by(string field, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $error("%s mismatch: expected %0d, got %0d", field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : monitor
    lnps_out_t want;
    int        bad;
    if (!rst_n) begin
      held_n          = 0;
      answer_q.delete();
      fail_count      = 0;
      words_waiting   = 0;
      words_checked   = 0;
      full_drops      = 0;
      absent_releases = 0;
      peak_depth      = 0;
    end else begin
      // the result leaving now belongs to an earlier word, so check it first
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $error("result word %h with nothing pending", out_data);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          bad  = off_by("sounding", 32'(want.sounding), 32'(out_data.sounding))
               + off_by("top_note", 32'(want.top_note), 32'(out_data.top_note))
               + off_by("top_freq", 32'(want.top_freq), 32'(out_data.top_freq))
               + off_by("top_velocity", 32'(want.top_velocity),
                        32'(out_data.top_velocity))
               + off_by("held_count", 32'(want.held_count),
                        32'(out_data.held_count))
               + off_by("status", 32'(want.status), 32'(out_data.status));
          if (bad != 0) fail_count++;
          words_checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = play_event(in_data);
        answer_q.push_back(want);
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_NOT_FOUND) absent_releases++;
        if (held_n > peak_depth) peak_depth = held_n;
      end
      words_waiting = answer_q.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lnps_pkg::*;

  localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
  localparam int RANDOM_WORDS = 1200;

  // Phase flavors for the random part: mostly presses, mostly releases, even mix.
  typedef enum int {FILL, DRAIN, MIXED} phase_kind_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid, in_ready;
  logic      out_valid, out_ready;
  lnps_in_t  in_data;
  lnps_out_t out_data;

  int fail_count, words_waiting, words_checked;
  int full_drops, absent_releases, peak_depth;

  // Stimulus-side view of which notes are down, used only to aim releases.
  logic [6:0] held_notes [$];
  int         presses, releases;
  bit         in_steady, out_steady;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  last_note_priority_stack #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lnps_scoreboard #(.STACK_DEPTH(STACK_DEPTH)) board (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .words_waiting   (words_waiting),
    .words_checked   (words_checked),
    .full_drops      (full_drops),
    .absent_releases (absent_releases),
    .peak_depth      (peak_depth)
  );

  // Draw a random idle stretch; steady stretches never idle.
  function automatic int draw_wait(bit steady);
    return steady ? 0 : int'($urandom_range(0, 13));
  endfunction

  // Narrow phases crowd notes into a tiny pool so duplicates pile up.
  function automatic logic [6:0] pick_note(bit narrow);
    return narrow ? 7'($urandom_range(60, 63)) : 7'($urandom_range(0, 127));
  endfunction

  // Present one word after a drawn gap and hold it until the block takes it.
  // Valid stays high across back-to-back words; it drops only for a real gap.
  task automatic send_word(logic cmd, logic [6:0] note, logic [23:0] freq,
                           logic [7:0] vel);
    int gap;
    int hit;
    gap = draw_wait(in_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, note_number: note, pitch_freq: freq,
                  key_velocity: vel};
    do @(posedge clk); while (!in_ready);
    // track held notes the same way the stack does, so releases hit often
    if (cmd == CMD_PRESS) begin
      presses++;
      if (held_notes.size() < STACK_DEPTH) held_notes.push_back(note);
    end else begin
      releases++;
      hit = -1;
      foreach (held_notes[i]) if (hit < 0 && held_notes[i] == note) hit = i;
      if (hit >= 0) held_notes.delete(hit);
    end
  endtask

  // Result side: stall a drawn number of cycles before each word, switching
  // between stalling and steady stretches every few dozen results.
  initial begin : result_sink
    int stall;
    int left;
    out_ready <= 1'b0;
    out_steady = 1'b0;
    left       = 0;
    forever begin
      if (left == 0) begin
        out_steady = ($urandom_range(0, 3) == 0);
        left       = $urandom_range(10, 60);
      end
      left--;
      stall = draw_wait(out_steady);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    phase_kind_t kind;
    int          phase_len;
    int          press_pct;
    int          sent;
    bit          narrow;
    logic [6:0]  target;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    presses   = 0;
    releases  = 0;
    in_steady = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: release on an empty stack, field extremes, a duplicate
    // note where only the oldest copy goes, an absent release, top removal,
    // bottom removal, draining to empty and one more release on empty.
    send_word(CMD_RELEASE, 7'd10,  24'hFFFFFF, 8'hFF);
    send_word(CMD_PRESS,   7'd0,   24'h000000, 8'h00);
    send_word(CMD_PRESS,   7'd127, 24'hFFFFFF, 8'hFF);
    send_word(CMD_PRESS,   7'd60,  24'h5A5A5A, 8'hA5);
    send_word(CMD_PRESS,   7'd127, 24'hA5A5A5, 8'h5A);
    send_word(CMD_RELEASE, 7'd127, 24'h000000, 8'h00);
    send_word(CMD_RELEASE, 7'd99,  24'h123456, 8'h77);
    send_word(CMD_RELEASE, 7'd127, 24'hFFFFFF, 8'hFF);
    send_word(CMD_RELEASE, 7'd0,   24'h000000, 8'h00);
    send_word(CMD_RELEASE, 7'd60,  24'h000000, 8'h00);
    send_word(CMD_RELEASE, 7'd60,  24'h000000, 8'h00);
    send_word(CMD_PRESS,   7'd1,   24'h000400, 8'h80);
    send_word(CMD_RELEASE, 7'd1,   24'hFFFFFF, 8'hFF);

    // Random part in phases; open with a fill phase so overflow shows up early.
    sent = 0;
    kind = FILL;
    while (sent < RANDOM_WORDS) begin
      phase_len = $urandom_range(20, 80);
      in_steady = ($urandom_range(0, 3) == 0);
      narrow    = ($urandom_range(0, 2) == 0);
      case (kind)
        FILL:    press_pct = 85;
        DRAIN:   press_pct = 20;
        default: press_pct = 50;
      endcase
      repeat (phase_len) begin
        if ($urandom_range(1, 100) <= press_pct) begin
          send_word(CMD_PRESS, pick_note(narrow), 24'($urandom), 8'($urandom));
        end else begin
          // aim most releases at a held note, the rest anywhere
          if (held_notes.size() > 0 && $urandom_range(0, 9) < 8)
            target = held_notes[$urandom_range(0, held_notes.size() - 1)];
          else
            target = pick_note(narrow);
          send_word(CMD_RELEASE, target, 24'($urandom), 8'($urandom));
        end
        sent++;
      end
      kind = phase_kind_t'($urandom_range(0, 2));
    end
    in_valid <= 1'b0;

    // Drain: wait for every answer, then give stray words time to show up.
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d words (%0d presses, %0d releases), checked %0d results.",
             presses + releases, presses, releases, words_checked);
    $display("Presses dropped on a full stack: %0d, releases of absent notes: %0d,",
             full_drops, absent_releases);
    $display("deepest stack: %0d.", peak_depth);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d result words mismatched", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results outstanding", words_waiting);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lnps_pkg.sv
hw/rtl/lnps_datapath.sv
hw/rtl/lnps_ctrl.sv
hw/rtl/last_note_priority_stack.sv
sim/lnps_scoreboard.sv
sim/testbench.sv
